@@ hdl/slsc_pkg.sv @@
// Shared types and character constants for the shell line syntax checker.
package slsc_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_BQUOTE = 8'h60;
    localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SQUOTE = 3'd1,
        MODE_DQUOTE = 3'd2,
        MODE_GT1    = 3'd3,
        MODE_REDIR  = 3'd4,
        MODE_PIPE   = 3'd5,
        MODE_SEMI   = 3'd6
    } scan_mode_t;

    typedef struct packed {
        logic              take;
        logic [CHAR_W-1:0] character;
        logic              end_of_line;
    } step_t;

    typedef struct packed {
        logic valid;
        logic syntax_ok;
    } verdict_t;

endpackage

@@ hdl/slsc_scan.sv @@
// Scan state registers and per-byte next-state logic of the syntax checker.
module slsc_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  slsc_pkg::step_t   step,
    output slsc_pkg::verdict_t verdict
);
    import slsc_pkg::*;

    scan_mode_t        mode_reg, mode_next;
    logic              bs_reg, bs_next;
    logic              word_reg, word_next;
    logic              err_reg, err_next;

    logic [CHAR_W-1:0] c;
    logic              line_end;
    logic              esc;
    logic              is_forbidden, is_operator, is_pipe_semi;
    scan_mode_t        nrm_mode;
    logic              nrm_bs, nrm_word, nrm_err;
    logic              mode_ok;

    assign c            = step.character;
    assign line_end     = step.end_of_line || (c == CH_NUL);
    assign is_forbidden = (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_AMP)
                          || (c == CH_BQUOTE);
    assign is_pipe_semi = (c == CH_PIPE) || (c == CH_SEMI);
    assign is_operator  = is_pipe_semi || (c == CH_GT) || (c == CH_LT);

    // Leaving an operator mode clears the escape before the normal path runs.
    always_comb
    begin
        case (mode_reg)
            MODE_SQUOTE, MODE_DQUOTE, MODE_GT1, MODE_REDIR, MODE_PIPE, MODE_SEMI:
                esc = 1'b0;
            default:
                esc = bs_reg;
        endcase
    end

    always_comb
    begin
        nrm_mode = MODE_NORMAL;
        nrm_bs   = (c == CH_BSLASH);
        nrm_word = word_reg;
        nrm_err  = err_reg;
        if (!esc && is_forbidden) begin
            nrm_err = 1'b1;
        end else if (!esc && c == CH_SQUOTE) begin
            nrm_mode = MODE_SQUOTE;
        end else if (!esc && c == CH_DQUOTE) begin
            nrm_mode = MODE_DQUOTE;
        end else if (!esc && is_operator) begin
            if (c == CH_GT) begin
                nrm_mode = MODE_GT1;
            end else if (c == CH_LT) begin
                nrm_mode = MODE_REDIR;
            end else if (c == CH_PIPE) begin
                nrm_mode = MODE_PIPE;
            end else begin
                nrm_mode = MODE_SEMI;
            end
            if (is_pipe_semi && !word_reg) begin
                nrm_err = 1'b1;
            end
        end else if (c != CH_SPACE) begin
            nrm_word = 1'b1;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SQUOTE, MODE_DQUOTE, MODE_GT1, MODE_REDIR, MODE_PIPE:
                mode_ok = 1'b0;
            default:
                mode_ok = 1'b1;
        endcase
    end

    assign verdict.valid     = step.take && line_end;
    assign verdict.syntax_ok = !err_reg && mode_ok;

    always_comb
    begin
        mode_next = mode_reg;
        bs_next   = bs_reg;
        word_next = word_reg;
        err_next  = err_reg;
        if (step.take) begin
            if (line_end) begin
                mode_next = MODE_NORMAL;
                bs_next   = 1'b0;
                word_next = 1'b0;
                err_next  = 1'b0;
            end else if (!err_reg) begin
                case (mode_reg)
                    MODE_SQUOTE, MODE_DQUOTE:
                    begin
                        if (!bs_reg && ((mode_reg == MODE_SQUOTE && c == CH_SQUOTE)
                                || (mode_reg == MODE_DQUOTE && c == CH_DQUOTE))) begin
                            mode_next = MODE_NORMAL;
                            bs_next   = 1'b0;
                        end else begin
                            bs_next = (c == CH_BSLASH);
                        end
                    end
                    MODE_GT1, MODE_REDIR:
                    begin
                        bs_next = 1'b0;
                        if ((mode_reg == MODE_GT1 && c == CH_GT) || c == CH_SPACE) begin
                            mode_next = MODE_REDIR;
                        end else if (is_operator) begin
                            err_next = 1'b1;
                        end else begin
                            mode_next = nrm_mode;
                            bs_next   = nrm_bs;
                            word_next = nrm_word;
                            err_next  = nrm_err;
                        end
                    end
                    MODE_PIPE, MODE_SEMI:
                    begin
                        bs_next = 1'b0;
                        if (c == CH_SPACE) begin
                            mode_next = mode_reg;
                        end else if (is_pipe_semi) begin
                            err_next = 1'b1;
                        end else begin
                            mode_next = nrm_mode;
                            bs_next   = nrm_bs;
                            word_next = nrm_word;
                            err_next  = nrm_err;
                        end
                    end
                    default:
                    begin
                        mode_next = nrm_mode;
                        bs_next   = nrm_bs;
                        word_next = nrm_word;
                        err_next  = nrm_err;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            bs_reg   <= 1'b0;
            word_reg <= 1'b0;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            bs_reg   <= bs_next;
            word_reg <= word_next;
            err_reg  <= err_next;
        end
    end

endmodule

@@ hdl/shell_line_syntax_check_unit.sv @@
// Top level of the shell command line syntax checker with stream ports.
// A verdict is registered once the scan logic takes its end-of-line word from the input register.
// Throughput: one word per cycle; the input register and the verdict register form
// a two-stage pipeline that stalls only when both registers are full and the verdict is not taken.
// Reset clears both valid flags and the scan state, so the first line starts clean.
module shell_line_syntax_check_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // character
    input  logic       s_tlast,   // end_of_line
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // syntax_ok, then zero fill
);
    import slsc_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              in_eol_reg, in_eol_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic              advance;
    step_t             step;
    verdict_t          verdict;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign step.take        = in_valid_reg && advance;
    assign step.character   = in_char_reg;
    assign step.end_of_line = in_eol_reg;

    slsc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (verdict)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_char_next   = in_char_reg;
        in_eol_next    = in_eol_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_char_next  = s_tdata;
            in_eol_next   = s_tlast;
        end
        if (advance) begin
            out_valid_next = verdict.valid;
            out_ok_next    = verdict.syntax_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
        in_eol_reg  <= in_eol_next;
        out_ok_reg  <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};

endmodule
